[design/rrg_pkg.sv]
// ----------------------------------------------------------------------------
// rrg_pkg
// Shared types and codes for the ratio reduction block: opcodes, status
// codes and the sequencer states.
// ----------------------------------------------------------------------------
package rrg_pkg;

   localparam int OPCODE_W = 2;
   localparam int STATUS_W = 2;

   typedef logic [OPCODE_W-1:0] opcode_type;
   typedef logic [STATUS_W-1:0] status_type;

   // Opcodes. The unused code behaves like a plain simplify.
   localparam opcode_type OP_SIMPLIFY = 2'd0;
   localparam opcode_type OP_START    = 2'd1;
   localparam opcode_type OP_COMPARE  = 2'd2;

   // Result status codes.
   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_ZERO_DEN = 2'd1;
   localparam status_type ST_OVERFLOW = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_GCD,
      S_GCD_WAIT,
      S_QN,
      S_QN_WAIT,
      S_QD,
      S_QD_WAIT,
      S_DONE
   } state_type;

endpackage

[design/rrg_req_if.sv]
// ----------------------------------------------------------------------------
// rrg_req_if
// Request channel: an opcode and a signed ratio, with valid/ready.
// ----------------------------------------------------------------------------
interface rrg_req_if #(
   parameter int WIDTH = 32
);
   logic                    valid;
   logic                    ready;
   rrg_pkg::opcode_type     opcode;
   logic signed [WIDTH-1:0] numerator;
   logic signed [WIDTH-1:0] denominator;

   modport source (output valid, output opcode, output numerator,
                   output denominator, input ready);
   modport sink   (input valid, input opcode, input numerator,
                   input denominator, output ready);
endinterface

[design/rrg_rsp_if.sv]
// ----------------------------------------------------------------------------
// rrg_rsp_if
// Response channel: the reduced ratio, a status code and the group flag.
// ----------------------------------------------------------------------------
interface rrg_rsp_if #(
   parameter int WIDTH = 32
);
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] reduced_num;
   logic [WIDTH-2:0]        reduced_den;
   rrg_pkg::status_type     status;
   logic                    all_equal;

   modport source (output valid, output reduced_num, output reduced_den,
                   output status, output all_equal, input ready);
   modport sink   (input valid, input reduced_num, input reduced_den,
                   input status, input all_equal, output ready);
endinterface

[design/rrg_div.sv]
// ----------------------------------------------------------------------------
// rrg_div
// Restoring unsigned divider, one quotient bit per cycle. Gives quotient
// and remainder together; the divisor must be nonzero.
// ----------------------------------------------------------------------------
module rrg_div #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);
   localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;

   assign shifted = {rem_ff, quo_ff[WIDTH-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WIDTH - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // A borrow out of the top bit means the divisor did not fit.
         if (!diff[WIDTH]) begin
            rem_in = diff[WIDTH-1:0];
         end else begin
            rem_in = shifted[WIDTH-1:0];
         end
         quo_in = {quo_ff[WIDTH-2:0], !diff[WIDTH]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[design/ratio_reduce_gcd.sv]
// ----------------------------------------------------------------------------
// ratio_reduce_gcd
// Reduces a signed ratio to lowest terms with a non-negative denominator,
// and tracks whether every ratio of a group equals the group's base.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload                                   Handshake
//   req_ch   in         opcode, numerator, denominator            valid/ready
//   rsp_ch   out        reduced_num, reduced_den, status,         valid/ready
//                       all_equal
//
// One divider serves every step: each Euclid remainder step and the two
// exact divisions by the GCD each go through a start, WIDTH bit steps and
// a result. An item takes k remainder steps, where k is at most about
// 1.44 * WIDTH; a zero denominator error goes straight from the idle state
// to the last state.
// Reset is synchronous and clears the sequencer, the output valid, the group
// base (0/0) and sets the all-equal flag.
// The request side is ready only while the sequencer idles. A finished item
// sits in the output register, so a new item is taken while it waits; a
// later result waits in the last state until the output register is free.
module ratio_reduce_gcd #(
   parameter int WIDTH = 32
) (
   input  logic     clock,
   input  logic     reset,
   rrg_req_if.sink  req_ch,
   rrg_rsp_if.source rsp_ch
);
   import rrg_pkg::*;

   // Sequencer and working registers.
   state_type        state_ff, state_in;
   logic [WIDTH-1:0] x_ff, x_in;         // Euclid pair, x ends up as the GCD
   logic [WIDTH-1:0] y_ff, y_in;
   logic [WIDTH-1:0] nmag_ff, nmag_in;   // magnitudes, later the quotients
   logic [WIDTH-1:0] dmag_ff, dmag_in;
   logic             nneg_ff, nneg_in;
   logic             dneg_ff, dneg_in;
   logic             err_ff, err_in;
   opcode_type       op_ff, op_in;

   // Group state.
   logic [WIDTH-1:0] base_num_ff, base_num_in;
   logic [WIDTH-1:0] base_den_ff, base_den_in;
   logic             match_ff, match_in;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0] rsp_num_ff, rsp_num_in;
   logic [WIDTH-2:0] rsp_den_ff, rsp_den_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic             rsp_eq_ff, rsp_eq_in;

   // Divider connection.
   logic             div_start;
   logic [WIDTH-1:0] div_dividend;
   logic [WIDTH-1:0] div_divisor;
   logic             div_done;
   logic [WIDTH-1:0] div_quo;
   logic [WIDTH-1:0] div_rem;

   // Request decode.
   logic             accept;
   logic [WIDTH-1:0] req_num;
   logic [WIDTH-1:0] req_den;
   logic [WIDTH-1:0] req_nmag;
   logic [WIDTH-1:0] req_dmag;
   logic             req_group;
   logic             req_zero_err;

   // Final formatting.
   logic             fin_neg;
   logic             fin_ok;
   status_type       fin_status;
   logic [WIDTH-1:0] fin_num;
   logic [WIDTH-2:0] fin_den;
   logic             is_start;
   logic             is_cmp;
   logic             fin_match;
   logic             out_free;
   logic             load_out;

   rrg_div #(
      .WIDTH(WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Split the incoming ratio into signs and magnitudes. The magnitude of
   // the most negative value is 2^(WIDTH-1), which still fits unsigned.
   assign accept   = req_ch.valid && req_ch.ready;
   assign req_num  = req_ch.numerator;
   assign req_den  = req_ch.denominator;
   assign req_nmag = req_num[WIDTH-1] ? (~req_num + 1'b1) : req_num;
   assign req_dmag = req_den[WIDTH-1] ? (~req_den + 1'b1) : req_den;
   assign req_group = (req_ch.opcode == OP_START) || (req_ch.opcode == OP_COMPARE);
   // Zero over zero is always an error; nonzero over zero only outside groups.
   assign req_zero_err = (req_dmag == '0) && (!req_group || (req_nmag == '0));

   // After both divisions nmag_ff and dmag_ff hold the reduced magnitudes.
   // The sign goes on the numerator unless either part is zero.
   assign fin_neg = (nneg_ff != dneg_ff) && (nmag_ff != '0) && (dmag_ff != '0);

   always_comb begin
      if (err_ff) begin
         fin_status = ST_ZERO_DEN;
      end else if (dmag_ff[WIDTH-1] || (!fin_neg && nmag_ff[WIDTH-1])) begin
         fin_status = ST_OVERFLOW;
      end else begin
         fin_status = ST_OK;
      end
   end

   assign fin_ok   = (fin_status == ST_OK);
   assign fin_num  = !fin_ok ? '0 : (fin_neg ? (~nmag_ff + 1'b1) : nmag_ff);
   assign fin_den  = fin_ok ? dmag_ff[WIDTH-2:0] : '0;
   assign is_start = (op_ff == OP_START);
   assign is_cmp   = (op_ff == OP_COMPARE);

   always_comb begin
      if (is_start) begin
         fin_match = fin_ok;
      end else if (is_cmp) begin
         fin_match = match_ff && fin_ok && (fin_num == base_num_ff)
                     && ({1'b0, fin_den} == base_den_ff);
      end else begin
         fin_match = match_ff;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = req_zero_err ? S_DONE : S_GCD;
            end
         end
         S_GCD: begin
            state_in = (y_ff == '0) ? S_QN : S_GCD_WAIT;
         end
         S_GCD_WAIT: begin
            if (div_done) begin
               state_in = S_GCD;
            end
         end
         S_QN: begin
            state_in = S_QN_WAIT;
         end
         S_QN_WAIT: begin
            if (div_done) begin
               state_in = S_QD;
            end
         end
         S_QD: begin
            state_in = S_QD_WAIT;
         end
         S_QD_WAIT: begin
            if (div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer outputs. The GCD sits in x once y has reached zero, so both
   // exact divisions use x as the divisor.
   always_comb begin
      req_ch.ready = 1'b0;
      div_start    = 1'b0;
      div_dividend = dmag_ff;
      div_divisor  = x_ff;
      load_out     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ch.ready = 1'b1;
         end
         S_GCD: begin
            div_start    = (y_ff != '0);
            div_dividend = x_ff;
            div_divisor  = y_ff;
         end
         S_QN: begin
            div_start    = 1'b1;
            div_dividend = nmag_ff;
         end
         S_QD: begin
            div_start    = 1'b1;
         end
         S_DONE: begin
            load_out = out_free;
         end
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      x_in          = x_ff;
      y_in          = y_ff;
      nmag_in       = nmag_ff;
      dmag_in       = dmag_ff;
      nneg_in       = nneg_ff;
      dneg_in       = dneg_ff;
      err_in        = err_ff;
      op_in         = op_ff;
      base_num_in   = base_num_ff;
      base_den_in   = base_den_ff;
      match_in      = match_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_num_in    = rsp_num_ff;
      rsp_den_in    = rsp_den_ff;
      rsp_status_in = rsp_status_ff;
      rsp_eq_in     = rsp_eq_ff;

      if (accept) begin
         x_in    = req_nmag;
         y_in    = req_dmag;
         nmag_in = req_nmag;
         dmag_in = req_dmag;
         nneg_in = req_num[WIDTH-1];
         dneg_in = req_den[WIDTH-1];
         err_in  = req_zero_err;
         op_in   = req_ch.opcode;
      end

      if (div_done) begin
         case (state_ff)
            S_GCD_WAIT: begin
               x_in = y_ff;
               y_in = div_rem;
            end
            S_QN_WAIT: begin
               nmag_in = div_quo;
            end
            S_QD_WAIT: begin
               dmag_in = div_quo;
            end
            default: begin
            end
         endcase
      end

      if (load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_num_in    = fin_num;
         rsp_den_in    = fin_den;
         rsp_status_in = fin_status;
         rsp_eq_in     = fin_match;
         match_in      = fin_match;
         if (is_start && fin_ok) begin
            base_num_in = fin_num;
            base_den_in = {1'b0, fin_den};
         end
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         base_num_ff  <= '0;
         base_den_ff  <= '0;
         match_ff     <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         base_num_ff  <= base_num_in;
         base_den_ff  <= base_den_in;
         match_ff     <= match_in;
      end
      x_ff          <= x_in;
      y_ff          <= y_in;
      nmag_ff       <= nmag_in;
      dmag_ff       <= dmag_in;
      nneg_ff       <= nneg_in;
      dneg_ff       <= dneg_in;
      err_ff        <= err_in;
      op_ff         <= op_in;
      rsp_num_ff    <= rsp_num_in;
      rsp_den_ff    <= rsp_den_in;
      rsp_status_ff <= rsp_status_in;
      rsp_eq_ff     <= rsp_eq_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.reduced_num = rsp_num_ff;
   assign rsp_ch.reduced_den = rsp_den_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.all_equal   = rsp_eq_ff;

   // The divider only finishes while the sequencer waits for it.
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_GCD_WAIT || state_ff == S_QN_WAIT
                    || state_ff == S_QD_WAIT))
      else $error("divider finished outside a wait state");

   // Without a zero denominator error the GCD is never zero.
   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_QN) |-> (x_ff != '0))
      else $error("GCD is zero at the first exact division");

   // A failed item carries a zero ratio.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK)
         |-> (rsp_num_ff == '0 && rsp_den_ff == '0))
      else $error("error result with a nonzero ratio");

   // An accepted item always leaves the idle state.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("sequencer stayed idle after taking an item");

endmodule
